FILE: rtl/clock_controlled_lfsr_keystream_defines.svh
// assertion macros for the clock controlled lfsr keystream block
// used by rtl/clock_controlled_lfsr_keystream.sv, no other dependencies
`ifndef CLOCK_CONTROLLED_LFSR_KEYSTREAM_DEFINES_SVH
`define CLOCK_CONTROLLED_LFSR_KEYSTREAM_DEFINES_SVH

`ifndef SYNTHESIS

`define CCL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define CCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define CCL_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define CCL_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/ccl_pkg.sv
// constants, types and lfsr step functions for the keystream generator
// no dependencies
`default_nettype none

package ccl_pkg;

    localparam int unsigned NUM_LFSR  = 5;
    localparam int unsigned REG_W     = 32;
    localparam int unsigned LFSR_IDXW = 3;
    localparam int unsigned CFG_IDXW  = 3;

    typedef logic [REG_W-1:0]     t_word;
    typedef logic [LFSR_IDXW-1:0] t_lfsr_idx;
    typedef logic [CFG_IDXW-1:0]  t_cfg_idx;

    localparam t_cfg_idx IDX_SEED_A = 3'd0;
    localparam t_cfg_idx IDX_SEED_B = 3'd1;
    localparam t_cfg_idx IDX_SEED_C = 3'd2;
    localparam t_cfg_idx IDX_SEED_D = 3'd3;
    localparam t_cfg_idx IDX_SEED_E = 3'd4;

    localparam t_word TAP_MASK [NUM_LFSR] = '{
        32'h4000_1000,
        32'h0004_0013,
        32'h0001_0010,
        32'h0000_100D,
        32'h8000_0057
    };

    localparam t_word TOP_BIT [NUM_LFSR] = '{
        32'h4000_0000,
        32'h0004_0000,
        32'h0001_0000,
        32'h0000_1000,
        32'h8000_0000
    };

    localparam t_word SEED_RESET [NUM_LFSR] = '{
        32'hFEED_BABE,
        32'h0DEA_FDAD,
        32'hFEED_F00D,
        32'h00BA_DCAB,
        32'hDEAD_BEEF
    };

    typedef struct packed {
        logic  key;
        t_word next;
    } t_step;

    function automatic t_step lfsr_once(input t_word r, input t_lfsr_idx k);
        t_word v;
        t_step s;
        v = (r == '0) ? t_word'(1) : r;
        if (v[0]) begin
            s.key  = 1'b1;
            s.next = ((v ^ TAP_MASK[k]) >> 1) | TOP_BIT[k];
        end else begin
            s.key  = 1'b0;
            s.next = v >> 1;
        end
        return s;
    endfunction

    // two steps are built in parallel with one, skip picks the result
    function automatic t_step lfsr_clocked(input t_word r, input t_lfsr_idx k,
                                           input logic skip);
        t_step s1;
        t_step s2;
        s1 = lfsr_once(r, k);
        s2 = lfsr_once(s1.next, k);
        return skip ? s2 : s1;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/clock_controlled_lfsr_keystream.sv
// keystream generator: five galois lfsrs, clock controlled, in a bridge arrangement
// depends on rtl/ccl_pkg.sv and rtl/clock_controlled_lfsr_keystream_defines.svh
//
//  channel   direction  handshake                   payload
//  input     in         i_valid / o_ready           i_reseed
//  output    out        o_valid / i_ready           o_key_bit
//  config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// one item per cycle while i_ready holds; o_valid is the output register's flag
// the input register feeds a single pass of lfsr steps into the output register
// reset loads seeds and lfsr state with the reset seed values, prev bit zero
// an output stall backs up into the input register, then drops o_ready
// config writes are always taken and reach the lfsrs only on a reseed
`default_nettype none

`include "clock_controlled_lfsr_keystream_defines.svh"

module clock_controlled_lfsr_keystream (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic                     i_reseed,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic                          o_key_bit,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire ccl_pkg::t_cfg_idx        i_cfg_index,
    input  wire ccl_pkg::t_word           i_cfg_data
);

    ccl_pkg::t_word r_seed [ccl_pkg::NUM_LFSR];
    ccl_pkg::t_word r_sr   [ccl_pkg::NUM_LFSR];
    ccl_pkg::t_word n_sr   [ccl_pkg::NUM_LFSR];
    ccl_pkg::t_word w_src  [ccl_pkg::NUM_LFSR];
    logic           r_prev;
    logic           r_in_valid;
    logic           r_in_reseed;
    logic           r_out_valid;
    logic           r_key_bit;
    logic           n_key_bit;
    logic           w_fire;
    logic           w_prev_src;
    ccl_pkg::t_step w_s0;
    ccl_pkg::t_step w_s1;
    ccl_pkg::t_step w_s2;
    ccl_pkg::t_step w_s3;
    ccl_pkg::t_step w_s4;

    assign w_fire      = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready     = !r_in_valid || w_fire;
    assign o_valid     = r_out_valid;
    assign o_key_bit   = r_key_bit;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        for (int k = 0; k < ccl_pkg::NUM_LFSR; k++) begin
            w_src[k] = r_in_reseed ? r_seed[k] : r_sr[k];
        end
        w_prev_src = r_in_reseed ? 1'b0 : r_prev;

        w_s0 = ccl_pkg::lfsr_clocked(w_src[0], ccl_pkg::t_lfsr_idx'(0), w_prev_src);
        w_s1 = ccl_pkg::lfsr_clocked(w_src[1], ccl_pkg::t_lfsr_idx'(1), w_prev_src);
        w_s2 = ccl_pkg::lfsr_clocked(w_src[2], ccl_pkg::t_lfsr_idx'(2), w_s0.key);
        w_s3 = ccl_pkg::lfsr_clocked(w_src[3], ccl_pkg::t_lfsr_idx'(3), w_s0.key);
        w_s4 = ccl_pkg::lfsr_clocked(w_src[4], ccl_pkg::t_lfsr_idx'(4),
                                     w_s1.key ^ w_s2.key);

        n_sr[0]   = w_s0.next;
        n_sr[1]   = w_s1.next;
        n_sr[2]   = w_s2.next;
        n_sr[3]   = w_s3.next;
        n_sr[4]   = w_s4.next;
        n_key_bit = w_s3.key ^ w_s4.key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev      <= 1'b0;
            for (int k = 0; k < ccl_pkg::NUM_LFSR; k++) begin
                r_seed[k] <= ccl_pkg::SEED_RESET[k];
                r_sr[k]   <= ccl_pkg::SEED_RESET[k];
            end
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
                r_prev      <= n_key_bit;
                for (int k = 0; k < ccl_pkg::NUM_LFSR; k++) begin
                    r_sr[k] <= n_sr[k];
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    ccl_pkg::IDX_SEED_A: r_seed[0] <= i_cfg_data;
                    ccl_pkg::IDX_SEED_B: r_seed[1] <= i_cfg_data;
                    ccl_pkg::IDX_SEED_C: r_seed[2] <= i_cfg_data;
                    ccl_pkg::IDX_SEED_D: r_seed[3] <= i_cfg_data;
                    ccl_pkg::IDX_SEED_E: r_seed[4] <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_in_reseed <= i_reseed;
        end
        if (w_fire) begin
            r_key_bit <= n_key_bit;
        end
    end

    // a step result always lands in the output register
    `CCL_ASSERT_NEXT(a_fire_out, i_clk, i_rst_n, w_fire, r_out_valid && (r_key_bit == r_prev))

    // lfsr state never rests at zero after a step
    `CCL_ASSERT_NEXT(a_state_nz, i_clk, i_rst_n, w_fire,
        (r_sr[0] != '0) && (r_sr[1] != '0) && (r_sr[2] != '0) &&
        (r_sr[3] != '0) && (r_sr[4] != '0))

    // a held input item is not dropped
    `CCL_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !w_fire,
        r_in_valid && $stable(r_in_reseed))

    // input is only refused while both registers are full and the output stalls
    `CCL_ASSERT_SAME(a_ready_stall, i_clk, i_rst_n, !o_ready,
        r_in_valid && r_out_valid && !i_ready)

endmodule

`default_nettype wire
